// File: rtl/core/ufrb_pkg.sv
// Shared constants, codes and payload types for the serial FIFO register block.
`timescale 1ns / 1ps
`default_nettype none
package ufrb_pkg;

  localparam int FIFO_DEPTH = 16;
  localparam int HALF_LEVEL = 8;
  localparam int PTR_SPAN   = 2 * FIFO_DEPTH;
  localparam int PTR_W      = $clog2(PTR_SPAN);
  localparam int ADDR_W     = $clog2(FIFO_DEPTH);
  localparam int CHAR_W     = 9;
  localparam int WORD_W     = 16;
  localparam int RETRY_W    = 8;

  localparam logic [WORD_W-1:0] STAT_RBF = 16'h0001;
  localparam logic [WORD_W-1:0] STAT_TE  = 16'h0002;
  localparam logic [WORD_W-1:0] STAT_THE = 16'h0004;
  localparam logic [WORD_W-1:0] STAT_RHF = 16'h0100;
  localparam logic [WORD_W-1:0] STAT_TF  = 16'h0200;
  localparam logic [WORD_W-1:0] CT_RXEN  = 16'h0100;

  typedef enum logic [1:0] {
    OP_BUS_READ  = 2'd0,
    OP_BUS_WRITE = 2'd1,
    OP_LINE_RX   = 2'd2,
    OP_TX_SLOT   = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    REG_BAUD     = 4'd0,
    REG_TX_DATA  = 4'd1,
    REG_RX_DATA  = 4'd2,
    REG_CTL      = 4'd3,
    REG_IRQ_EN   = 4'd4,
    REG_STA      = 4'd5,
    REG_GUARD    = 4'd6,
    REG_TMO      = 4'd7,
    REG_TX_FLUSH = 4'd8,
    REG_RX_FLUSH = 4'd9,
    REG_RETRY    = 4'd10
  } reg_idx_t;

  typedef struct packed {
    logic [1:0]        operation;
    logic [3:0]        reg_index;
    logic [WORD_W-1:0] write_data;
    logic [CHAR_W-1:0] line_char;
  } ufrb_in_t;

  typedef struct packed {
    logic [WORD_W-1:0] read_data;
    logic              irq;
    logic              tx_valid;
    logic [CHAR_W-1:0] tx_char;
    logic              rx_running;
    logic              tx_running;
    logic              rx_dropped;
  } ufrb_out_t;

  typedef struct packed {
    logic push;
    logic pop;
    logic clr;
  } fifo_cmd_t;

  typedef struct packed {
    logic [PTR_W-1:0]  level;
    logic [PTR_W-1:0]  level_nxt;
    logic [ADDR_W-1:0] wr_slot;
    logic [ADDR_W-1:0] rd_slot;
  } fifo_stat_t;

endpackage
`default_nettype wire

// File: rtl/core/ufrb_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module ufrb_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/ufrb_fifo_ptr.sv
// FIFO pointer pair: write/read pointers, fill level and memory slots.
`timescale 1ns / 1ps
`default_nettype none
module ufrb_fifo_ptr (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire ufrb_pkg::fifo_cmd_t cmd,
  output ufrb_pkg::fifo_stat_t     stat
);
  import ufrb_pkg::*;

  localparam logic [PTR_W-1:0] SPAN_T = PTR_W'(PTR_SPAN);
  localparam logic [PTR_W-1:0] LAST_P = PTR_W'(PTR_SPAN - 1);
  localparam logic [PTR_W-1:0] DEPTH_P = PTR_W'(FIFO_DEPTH);

  logic [PTR_W-1:0] wp_r, wp_nxt;
  logic [PTR_W-1:0] rp_r, rp_nxt;

  function automatic logic [PTR_W-1:0] fill(input logic [PTR_W-1:0] w,
                                            input logic [PTR_W-1:0] r);
    // SPAN_T wraps to zero when the span is a power of two; the sum wraps too.
    if (w >= r) begin
      return w - r;
    end
    return w - r + SPAN_T;
  endfunction

  function automatic logic [PTR_W-1:0] step(input logic [PTR_W-1:0] p);
    return (p == LAST_P) ? '0 : p + PTR_W'(1);
  endfunction

  function automatic logic [ADDR_W-1:0] slot(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] s;
    s = (p >= DEPTH_P) ? p - DEPTH_P : p;
    return s[ADDR_W-1:0];
  endfunction

  always_comb begin
    wp_nxt = wp_r;
    rp_nxt = rp_r;
    if (cmd.clr) begin
      wp_nxt = '0;
      rp_nxt = '0;
    end else begin
      if (cmd.push) begin
        wp_nxt = step(wp_r);
      end
      if (cmd.pop) begin
        rp_nxt = step(rp_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
    end else begin
      wp_r <= wp_nxt;
      rp_r <= rp_nxt;
    end
  end

  assign stat.level     = fill(wp_r, rp_r);
  assign stat.level_nxt = fill(wp_nxt, rp_nxt);
  assign stat.wr_slot   = slot(wp_r);
  assign stat.rd_slot   = slot(rp_r);

endmodule
`default_nettype wire

// File: rtl/core/uart_fifo_register_block.sv
// Top level: register file, FIFO control and result pipeline of the serial controller.
`timescale 1ns / 1ps
`default_nettype none
// Register side of a serial controller with a 16-entry transmit FIFO and a
// 16-entry receive FIFO, 9-bit characters. Each input item is a bus read, a
// bus write, a character from the line or a transmit slot; each item yields
// exactly one result item, in order. The block takes one item every cycle:
// unless the output stalls: all register, pointer and status updates happen
// in the cycle an item is accepted; its result passes through the registered
// read of the FIFO memory and an output register. The output register lets
// the block keep accepting while a finished result waits to be taken; with
// the output stalled it holds two items before it drops in_ready. Status
// bits follow the FIFO levels (RHF is set but a RXBUF read never clears it),
// and irq is (status AND interrupt enable) != 0 after the item. The FIFO
// storage needs no clearing after reset: only entries that were pushed are
// ever popped.
module uart_fifo_register_block (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire ufrb_pkg::ufrb_in_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output ufrb_pkg::ufrb_out_t      out_data
);
  import ufrb_pkg::*;

  // Result fields that are known at acceptance; FIFO data joins in the output register.
  typedef struct packed {
    logic [WORD_W-1:0] read_data;
    logic              rx_from_ram;
    logic              irq;
    logic              tx_valid;
    logic              rx_running;
    logic              tx_running;
    logic              rx_dropped;
  } stage_t;

  localparam logic [PTR_W-1:0] DEPTH_P = PTR_W'(FIFO_DEPTH);

  // Register file
  logic [WORD_W-1:0]  status_r, status_nxt;
  logic [WORD_W-1:0]  ctl_r, ctl_nxt;
  logic [WORD_W-1:0]  inten_r, inten_nxt;
  logic [WORD_W-1:0]  baud_r, baud_nxt;
  logic [CHAR_W-1:0]  guard_r, guard_nxt;
  logic [CHAR_W-1:0]  tmo_r, tmo_nxt;
  logic [RETRY_W-1:0] retry_r, retry_nxt;
  logic               rx_run_r, rx_run_nxt;
  logic               tx_run_r, tx_run_nxt;

  // Pipeline
  logic   s1_valid_r;
  stage_t s1_r, s1_nxt;
  logic   out_valid_r;
  ufrb_out_t out_r;

  logic accept;
  logic s1_move;

  fifo_cmd_t  tx_cmd, rx_cmd;
  fifo_stat_t tx_stat, rx_stat;

  logic [CHAR_W-1:0] tx_rd_data, rx_rd_data;

  op_t      op;
  reg_idx_t idx;

  assign op  = op_t'(in_data.operation);
  assign idx = reg_idx_t'(in_data.reg_index);

  // Advance stage 1 into the output register whenever that register frees up.
  assign s1_move  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_move;
  assign accept   = in_valid && in_ready;

  // FIFO commands depend only on current levels, never on updated ones.
  always_comb begin
    tx_cmd = '0;
    rx_cmd = '0;
    if (accept) begin
      unique case (op)
        OP_BUS_READ: begin
          rx_cmd.pop = (idx == REG_RX_DATA) && (rx_stat.level != '0);
        end
        OP_BUS_WRITE: begin
          tx_cmd.push = (idx == REG_TX_DATA) && (tx_stat.level < DEPTH_P);
          tx_cmd.clr  = (idx == REG_TX_FLUSH);
          rx_cmd.clr  = (idx == REG_RX_FLUSH);
        end
        OP_LINE_RX: begin
          rx_cmd.push = (rx_stat.level < DEPTH_P);
        end
        OP_TX_SLOT: begin
          tx_cmd.pop = (tx_stat.level != '0);
        end
        default: begin
        end
      endcase
    end
  end

  ufrb_fifo_ptr u_tx_ptr (
    .clk  (clk),
    .rst_n(rst_n),
    .cmd  (tx_cmd),
    .stat (tx_stat)
  );

  ufrb_fifo_ptr u_rx_ptr (
    .clk  (clk),
    .rst_n(rst_n),
    .cmd  (rx_cmd),
    .stat (rx_stat)
  );

  // Push and pop never touch the same entry in one cycle; a pop one item
  // after a push reads the entry already written.
  ufrb_ram #(.WIDTH(CHAR_W), .DEPTH(FIFO_DEPTH)) u_tx_ram (
    .clk    (clk),
    .wr_en  (tx_cmd.push),
    .wr_addr(tx_stat.wr_slot),
    .wr_data(in_data.write_data[CHAR_W-1:0]),
    .rd_en  (tx_cmd.pop),
    .rd_addr(tx_stat.rd_slot),
    .rd_data(tx_rd_data)
  );

  ufrb_ram #(.WIDTH(CHAR_W), .DEPTH(FIFO_DEPTH)) u_rx_ram (
    .clk    (clk),
    .wr_en  (rx_cmd.push),
    .wr_addr(rx_stat.wr_slot),
    .wr_data(in_data.line_char),
    .rd_en  (rx_cmd.pop),
    .rd_addr(rx_stat.rd_slot),
    .rd_data(rx_rd_data)
  );

  // Register updates and the early part of the result.
  always_comb begin
    status_nxt = status_r;
    ctl_nxt    = ctl_r;
    inten_nxt  = inten_r;
    baud_nxt   = baud_r;
    guard_nxt  = guard_r;
    tmo_nxt    = tmo_r;
    retry_nxt  = retry_r;
    rx_run_nxt = rx_run_r;
    tx_run_nxt = tx_run_r;
    s1_nxt     = '0;

    unique case (op)
      OP_BUS_READ: begin
        unique case (idx)
          REG_BAUD:    s1_nxt.read_data = baud_r;
          REG_RX_DATA: begin
            s1_nxt.rx_from_ram = rx_cmd.pop;
            if (rx_stat.level_nxt == '0) begin
              status_nxt = status_nxt & ~STAT_RBF;
            end
            if (int'(rx_stat.level_nxt) >= HALF_LEVEL) begin
              status_nxt = status_nxt | STAT_RHF;
            end
            if ((ctl_r & CT_RXEN) != '0) begin
              rx_run_nxt = 1'b1;
            end
          end
          REG_CTL:     s1_nxt.read_data = ctl_r;
          REG_IRQ_EN:  s1_nxt.read_data = inten_r;
          REG_STA:     s1_nxt.read_data = status_r;
          REG_GUARD:   s1_nxt.read_data = WORD_W'(guard_r);
          REG_TMO:     s1_nxt.read_data = WORD_W'(tmo_r);
          REG_RETRY:   s1_nxt.read_data = WORD_W'(retry_r);
          default:     s1_nxt.read_data = '0;
        endcase
      end
      OP_BUS_WRITE: begin
        unique case (idx)
          REG_BAUD: baud_nxt = in_data.write_data;
          REG_TX_DATA: begin
            // A full FIFO ignores the character but still updates flags.
            status_nxt = status_nxt & ~STAT_TE;
            if (int'(tx_stat.level_nxt) > FIFO_DEPTH - HALF_LEVEL) begin
              status_nxt = status_nxt & ~STAT_THE;
            end
            if (tx_stat.level_nxt == DEPTH_P) begin
              status_nxt = status_nxt | STAT_TF;
            end else begin
              status_nxt = status_nxt & ~STAT_TF;
            end
            tx_run_nxt = 1'b1;
          end
          REG_CTL: begin
            ctl_nxt = in_data.write_data;
            if ((in_data.write_data & CT_RXEN) != '0) begin
              rx_run_nxt = 1'b1;
            end
          end
          REG_IRQ_EN:   inten_nxt  = in_data.write_data;
          REG_STA:      status_nxt = in_data.write_data;
          REG_GUARD:    guard_nxt  = in_data.write_data[CHAR_W-1:0];
          REG_TMO:      tmo_nxt    = in_data.write_data[CHAR_W-1:0];
          REG_TX_FLUSH: status_nxt = (status_nxt | STAT_TE | STAT_THE) & ~STAT_TF;
          REG_RX_FLUSH: status_nxt = status_nxt & ~(STAT_RHF | STAT_RBF);
          REG_RETRY:    retry_nxt  = in_data.write_data[RETRY_W-1:0];
          default: begin
          end
        endcase
      end
      OP_LINE_RX: begin
        // Drop the character when full; level flags still refresh.
        s1_nxt.rx_dropped = !rx_cmd.push;
        if (rx_cmd.push && (rx_stat.level == DEPTH_P - PTR_W'(1))) begin
          rx_run_nxt = 1'b0;
        end
        if (rx_stat.level_nxt != '0) begin
          if (int'(rx_stat.level_nxt) >= HALF_LEVEL) begin
            status_nxt = status_nxt | STAT_RHF;
          end
          status_nxt = status_nxt | STAT_RBF;
        end
      end
      OP_TX_SLOT: begin
        s1_nxt.tx_valid = tx_cmd.pop;
        if (tx_stat.level_nxt == '0) begin
          status_nxt = status_nxt | STAT_TE;
          tx_run_nxt = 1'b0;
        end
        if (int'(tx_stat.level_nxt) <= HALF_LEVEL) begin
          status_nxt = status_nxt | STAT_THE;
        end
        if (tx_stat.level_nxt < DEPTH_P) begin
          status_nxt = status_nxt & ~STAT_TF;
        end
      end
      default: begin
      end
    endcase

    s1_nxt.irq        = ((status_nxt & inten_nxt) != '0);
    s1_nxt.rx_running = rx_run_nxt;
    s1_nxt.tx_running = tx_run_nxt;
  end

  // Commit register updates only for accepted items.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      status_r <= '0;
      ctl_r    <= '0;
      inten_r  <= '0;
      baud_r   <= '0;
      guard_r  <= '0;
      tmo_r    <= '0;
      retry_r  <= '0;
      rx_run_r <= 1'b0;
      tx_run_r <= 1'b0;
    end else if (accept) begin
      status_r <= status_nxt;
      ctl_r    <= ctl_nxt;
      inten_r  <= inten_nxt;
      baud_r   <= baud_nxt;
      guard_r  <= guard_nxt;
      tmo_r    <= tmo_nxt;
      retry_r  <= retry_nxt;
      rx_run_r <= rx_run_nxt;
      tx_run_r <= tx_run_nxt;
    end
  end

  // Stage 1: hold the early result while the RAM read completes. The RAM
  // data stays put while stage 1 stalls, since no new read issues until
  // stage 1 moves on.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_move) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r <= s1_nxt;
    end
  end

  // Output register: merge FIFO data into the result.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_move) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_r.read_data  <= s1_r.rx_from_ram ? WORD_W'(rx_rd_data) : s1_r.read_data;
      out_r.irq        <= s1_r.irq;
      out_r.tx_valid   <= s1_r.tx_valid;
      out_r.tx_char    <= s1_r.tx_valid ? tx_rd_data : '0;
      out_r.rx_running <= s1_r.rx_running;
      out_r.tx_running <= s1_r.tx_running;
      out_r.rx_dropped <= s1_r.rx_dropped;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

// File: tb/tb_uart_fifo_register_block.sv
// Self-checking testbench for the serial FIFO register block: directed table, then random traffic.
`timescale 1ns / 1ps
module tb_uart_fifo_register_block;
  import ufrb_pkg::*;

  // Random items per idling phase; four phases give about 1300 items.
  localparam int RANDOM_PER_PHASE = 325;
  // The result of an item comes out through stage 1 and the output register.
  localparam int DRAIN_CYCLES     = 4;
  localparam int DRAIN_LIMIT      = 20000;

  logic      clk;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  ufrb_in_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  ufrb_out_t out_data;

  // Percent of cycles in which the sender holds off or the receiver stalls.
  int idle_pct  = 0;
  int stall_pct = 0;

  int mismatches   = 0;
  int results_seen = 0;

  // Results the block owes, oldest first.
  ufrb_out_t results_due[$];

  // Shadow of the register file and both FIFOs, updated item by item.
  logic [CHAR_W-1:0]  tx_mem [FIFO_DEPTH];
  logic [CHAR_W-1:0]  rx_mem [FIFO_DEPTH];
  logic [PTR_W-1:0]   tx_wp = '0, tx_rp = '0, rx_wp = '0, rx_rp = '0;
  logic [WORD_W-1:0]  sta = '0, ctl = '0, ien = '0, baud = '0;
  logic [CHAR_W-1:0]  guard = '0, tmo = '0;
  logic [RETRY_W-1:0] retries = '0;
  logic               rx_run = 1'b0, tx_run = 1'b0;

  // One row of the directed table. Rows with known set carry a read value
  // that is obvious by inspection; they all come before any interrupt enable
  // or FIFO traffic, so every other field of their result is zero.
  typedef struct packed {
    op_t               op;
    logic [3:0]        idx;
    logic [WORD_W-1:0] wdata;
    logic [CHAR_W-1:0] ch;
    logic              known;
    logic [WORD_W-1:0] want_rd;
  } dir_row_t;

  localparam int N_DIRECTED = 27;
  localparam dir_row_t DIRECTED_ROWS [N_DIRECTED] = '{
    // op            idx           wdata     ch       known want_rd
    '{OP_BUS_READ,  REG_STA,      16'h0000, 9'h000, 1'b1, 16'h0000}, // status after reset
    '{OP_BUS_READ,  REG_RX_DATA,  16'hffff, 9'h1ff, 1'b1, 16'h0000}, // empty RX read
    '{OP_TX_SLOT,   REG_BAUD,     16'hffff, 9'h1ff, 1'b1, 16'h0000}, // empty TX slot
    '{OP_BUS_WRITE, REG_BAUD,     16'hffff, 9'h000, 1'b1, 16'h0000},
    '{OP_BUS_READ,  REG_BAUD,     16'h0000, 9'h000, 1'b1, 16'hffff},
    '{OP_BUS_WRITE, REG_GUARD,    16'hffff, 9'h000, 1'b1, 16'h0000},
    '{OP_BUS_READ,  REG_GUARD,    16'h0000, 9'h000, 1'b1, 16'h01ff},
    '{OP_BUS_WRITE, REG_TMO,      16'hffff, 9'h000, 1'b1, 16'h0000},
    '{OP_BUS_READ,  REG_TMO,      16'h0000, 9'h000, 1'b1, 16'h01ff},
    '{OP_BUS_WRITE, REG_RETRY,    16'hffff, 9'h000, 1'b1, 16'h0000},
    '{OP_BUS_READ,  REG_RETRY,    16'h0000, 9'h000, 1'b1, 16'h00ff},
    '{OP_BUS_WRITE, REG_IRQ_EN,   16'hffff, 9'h000, 1'b0, 16'h0000}, // irq from TE/THE
    '{OP_BUS_WRITE, REG_STA,      16'h0000, 9'h000, 1'b0, 16'h0000}, // irq drops at once
    '{OP_BUS_WRITE, REG_CTL,      16'h0100, 9'h000, 1'b0, 16'h0000}, // RX enable
    '{OP_BUS_WRITE, REG_TX_DATA,  16'hffff, 9'h000, 1'b0, 16'h0000},
    '{OP_BUS_WRITE, REG_TX_DATA,  16'h0000, 9'h1ff, 1'b0, 16'h0000},
    '{OP_TX_SLOT,   REG_BAUD,     16'h0000, 9'h000, 1'b0, 16'h0000},
    '{OP_TX_SLOT,   4'hf,         16'hffff, 9'h1ff, 1'b0, 16'h0000}, // TX drains empty
    '{OP_LINE_RX,   REG_BAUD,     16'h0000, 9'h1ff, 1'b0, 16'h0000},
    '{OP_LINE_RX,   4'hf,         16'hffff, 9'h000, 1'b0, 16'h0000},
    '{OP_BUS_READ,  REG_RX_DATA,  16'h0000, 9'h000, 1'b0, 16'h0000},
    '{OP_BUS_READ,  REG_RX_DATA,  16'h0000, 9'h000, 1'b0, 16'h0000},
    '{OP_BUS_WRITE, REG_RX_DATA,  16'hffff, 9'h1ff, 1'b0, 16'h0000}, // ignored
    '{OP_BUS_WRITE, REG_TX_FLUSH, 16'hffff, 9'h000, 1'b0, 16'h0000},
    '{OP_BUS_WRITE, REG_RX_FLUSH, 16'hffff, 9'h000, 1'b0, 16'h0000},
    '{OP_BUS_WRITE, 4'hf,         16'hffff, 9'h1ff, 1'b0, 16'h0000}, // unused index
    '{OP_BUS_READ,  REG_TX_FLUSH, 16'h0000, 9'h000, 1'b0, 16'h0000}  // write-only
  };

  uart_fifo_register_block u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Apply one item to the shadow state and return the result it produces.
  function automatic ufrb_out_t apply_item(ufrb_in_t it);
    ufrb_out_t        r;
    logic [PTR_W-1:0] cnt;
    int               room;
    r = '0;
    case (it.operation)
      OP_BUS_READ: begin
        case (it.reg_index)
          REG_BAUD:    r.read_data = baud;
          REG_CTL:     r.read_data = ctl;
          REG_IRQ_EN:  r.read_data = ien;
          REG_STA:     r.read_data = sta;
          REG_GUARD:   r.read_data = {7'd0, guard};
          REG_TMO:     r.read_data = {7'd0, tmo};
          REG_RETRY:   r.read_data = {8'd0, retries};
          REG_RX_DATA: begin
            // Pop if anything is there; RHF may be set here but is never cleared.
            if (rx_wp != rx_rp) begin
              r.read_data = {7'd0, rx_mem[rx_rp[ADDR_W-1:0]]};
              rx_rp = rx_rp + 1'b1;
            end
            cnt = rx_wp - rx_rp;
            if (cnt == 0) sta &= ~STAT_RBF;
            if (cnt >= HALF_LEVEL) sta |= STAT_RHF;
            if ((ctl & CT_RXEN) != 0) rx_run = 1'b1;
          end
          default: ;
        endcase
      end
      OP_BUS_WRITE: begin
        case (it.reg_index)
          REG_BAUD:    baud = it.write_data;
          REG_IRQ_EN:  ien = it.write_data;
          REG_STA:     sta = it.write_data;
          REG_GUARD:   guard = it.write_data[CHAR_W-1:0];
          REG_TMO:     tmo = it.write_data[CHAR_W-1:0];
          REG_RETRY:   retries = it.write_data[RETRY_W-1:0];
          REG_CTL: begin
            ctl = it.write_data;
            if ((it.write_data & CT_RXEN) != 0) rx_run = 1'b1;
          end
          REG_TX_DATA: begin
            // Drop the character when full, but still update the flags.
            if (PTR_W'(tx_wp - tx_rp) < FIFO_DEPTH) begin
              tx_mem[tx_wp[ADDR_W-1:0]] = it.write_data[CHAR_W-1:0];
              tx_wp = tx_wp + 1'b1;
            end
            room = FIFO_DEPTH - int'(PTR_W'(tx_wp - tx_rp));
            sta &= ~STAT_TE;
            if (room < HALF_LEVEL) sta &= ~STAT_THE;
            if (room > 0) sta &= ~STAT_TF;
            else sta |= STAT_TF;
            tx_run = 1'b1;
          end
          REG_TX_FLUSH: begin
            tx_wp = '0;
            tx_rp = '0;
            sta = (sta | STAT_TE | STAT_THE) & ~STAT_TF;
          end
          REG_RX_FLUSH: begin
            rx_wp = '0;
            rx_rp = '0;
            sta &= ~(STAT_RHF | STAT_RBF);
          end
          default: ;
        endcase
      end
      OP_LINE_RX: begin
        // Accept whenever there is room, regardless of the run flag.
        room = FIFO_DEPTH - int'(PTR_W'(rx_wp - rx_rp));
        if (room < 1) begin
          r.rx_dropped = 1'b1;
        end else begin
          rx_mem[rx_wp[ADDR_W-1:0]] = it.line_char;
          rx_wp = rx_wp + 1'b1;
          if (room == 1) rx_run = 1'b0;
        end
        cnt = rx_wp - rx_rp;
        if (cnt > 0) begin
          if (cnt >= HALF_LEVEL) sta |= STAT_RHF;
          sta |= STAT_RBF;
        end
      end
      default: begin
        // Transmit slot: pop one character if any.
        if (tx_wp != tx_rp) begin
          r.tx_char  = tx_mem[tx_rp[ADDR_W-1:0]];
          r.tx_valid = 1'b1;
          tx_rp = tx_rp + 1'b1;
        end
        cnt = tx_wp - tx_rp;
        if (cnt == 0) begin
          sta |= STAT_TE;
          tx_run = 1'b0;
        end
        if (cnt <= HALF_LEVEL) sta |= STAT_THE;
        if (cnt < FIFO_DEPTH) sta &= ~STAT_TF;
      end
    endcase
    r.irq        = (sta & ien) != 0;
    r.rx_running = rx_run;
    r.tx_running = tx_run;
    return r;
  endfunction

  // Fix the operation and register index; fill the data and line character at random.
  function automatic ufrb_in_t random_item(logic [1:0] op, logic [3:0] idx);
    ufrb_in_t it;
    it.operation  = op;
    it.reg_index  = idx;
    it.write_data = WORD_W'($urandom);
    it.line_char  = CHAR_W'($urandom);
    return it;
  endfunction

  task automatic flag_mismatch(input string field, input logic [WORD_W-1:0] got,
                               input logic [WORD_W-1:0] want);
    $display("mismatch at result %0d: %s got 0x%0h, expected 0x%0h",
             results_seen, field, got, want);
    mismatches++;
  endtask

  // Hold off at random, present the item, and hold it until it is taken.
  // Handshake signals are sampled right after the edge, so they carry the
  // values the block itself saw at that edge.
  task automatic send_item(input ufrb_in_t it);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    results_due.push_back(apply_item(it));
  endtask

  // Random traffic in bursts: fill and drain runs push both FIFOs to full and
  // empty over and over; single register accesses and raw noise mix in.
  task automatic run_random(input int target);
    int       done;
    int       pick;
    int       len;
    ufrb_in_t it;
    done = 0;
    while (done < target) begin
      pick = $urandom_range(99);
      len  = (pick < 75) ? $urandom_range(1, 20) : 1;
      for (int k = 0; k < len; k++) begin
        if (pick < 20)      it = random_item(OP_LINE_RX, 4'($urandom_range(15)));
        else if (pick < 40) it = random_item(OP_BUS_READ, REG_RX_DATA);
        else if (pick < 60) it = random_item(OP_BUS_WRITE, REG_TX_DATA);
        else if (pick < 75) it = random_item(OP_TX_SLOT, 4'($urandom_range(15)));
        else if (pick < 87) it = random_item(OP_BUS_WRITE, 4'($urandom_range(15)));
        else if (pick < 95) it = random_item(OP_BUS_READ, 4'($urandom_range(15)));
        else                it = random_item(2'($urandom_range(3)),
                                             4'($urandom_range(15)));
        send_item(it);
        // Writes the block throws away do not count toward the phase.
        if (!(it.operation == OP_BUS_WRITE &&
              (it.reg_index == REG_RX_DATA || it.reg_index > REG_RETRY)))
          done++;
      end
    end
  endtask

  // Receiver: stall at random at the current phase's rate.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // Compare every taken result, field by field, with the oldest one due.
  always @(posedge clk) begin : check_results
    ufrb_out_t want;
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      if (results_due.size() == 0) begin
        flag_mismatch("result with nothing due, read_data", out_data.read_data, '0);
      end else begin
        want = results_due.pop_front();
        if (out_data.read_data !== want.read_data)
          flag_mismatch("read_data", out_data.read_data, want.read_data);
        if (out_data.irq !== want.irq)
          flag_mismatch("irq", WORD_W'(out_data.irq), WORD_W'(want.irq));
        if (out_data.tx_valid !== want.tx_valid)
          flag_mismatch("tx_valid", WORD_W'(out_data.tx_valid), WORD_W'(want.tx_valid));
        if (out_data.tx_char !== want.tx_char)
          flag_mismatch("tx_char", WORD_W'(out_data.tx_char), WORD_W'(want.tx_char));
        if (out_data.rx_running !== want.rx_running)
          flag_mismatch("rx_running", WORD_W'(out_data.rx_running),
                        WORD_W'(want.rx_running));
        if (out_data.tx_running !== want.tx_running)
          flag_mismatch("tx_running", WORD_W'(out_data.tx_running),
                        WORD_W'(want.tx_running));
        if (out_data.rx_dropped !== want.rx_dropped)
          flag_mismatch("rx_dropped", WORD_W'(out_data.rx_dropped),
                        WORD_W'(want.rx_dropped));
      end
      results_seen++;
    end
  end

  initial begin
    ufrb_in_t  it;
    ufrb_out_t want;
    int        spins;

    // Hold reset once at the start, then release it.
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table, no idling on either side.
    foreach (DIRECTED_ROWS[i]) begin
      it.operation  = DIRECTED_ROWS[i].op;
      it.reg_index  = DIRECTED_ROWS[i].idx;
      it.write_data = DIRECTED_ROWS[i].wdata;
      it.line_char  = DIRECTED_ROWS[i].ch;
      send_item(it);
      // Replace the shadow's answer with the hand-written one where given.
      if (DIRECTED_ROWS[i].known) begin
        want           = '0;
        want.read_data = DIRECTED_ROWS[i].want_rd;
        results_due[$] = want;
      end
    end

    // Random phases: free running, sender idle, receiver stalling, both light.
    run_random(RANDOM_PER_PHASE);
    idle_pct  = 50;
    run_random(RANDOM_PER_PHASE);
    idle_pct  = 0;
    stall_pct = 50;
    run_random(RANDOM_PER_PHASE);
    idle_pct  = 6;
    stall_pct = 6;
    run_random(RANDOM_PER_PHASE);
    in_valid <= 1'b0;

    // Drain what is still due, then keep watching for stray results.
    spins = 0;
    while (results_due.size() != 0 && spins < DRAIN_LIMIT) begin
      @(posedge clk);
      spins++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && results_due.size() == 0) begin
      $display("tb_uart_fifo_register_block: PASS");
    end else begin
      $display("tb_uart_fifo_register_block: FAIL");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #400000;
    $display("tb_uart_fifo_register_block: FAIL");
    $finish;
  end

endmodule

// File: sim.f
rtl/core/ufrb_pkg.sv
rtl/core/ufrb_ram.sv
rtl/core/ufrb_fifo_ptr.sv
rtl/core/uart_fifo_register_block.sv
tb/tb_uart_fifo_register_block.sv
